// File: hdl/cma_pkg.sv
package cma_pkg;

    // Default sizing
    localparam int DEF_MAX_CLASSES = 16;
    localparam int DEF_COUNT_WIDTH = 32;

    // Field widths
    localparam int OP_W    = 2;
    localparam int CLS_W   = 4;
    localparam int SCORE_W = 16;
    localparam int WEIGHT_W = 8;
    localparam int WSCORE_W = SCORE_W + WEIGHT_W;
    localparam int READ_W  = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SCORE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_HIGH = 3'd4;

    localparam int CC_W = 5;

    // Register reset values
    localparam logic [CC_W-1:0]       RST_CLASS_COUNT = 5'd2;
    localparam logic [SCORE_W-1:0]    RST_THRESHOLD   = 16'h8000;
    localparam logic [CFG_DATA_W-1:0] RST_WEIGHTS     = 64'h0808_0808_0808_0808;

    // Hardware weight table covers this many classes
    localparam int WEIGHT_CLASSES = 16;

endpackage

// File: hdl/cma_ifs.sv
interface cma_item_if import cma_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       operation;
    logic [CLS_W-1:0]      class_index;
    logic [SCORE_W-1:0]    score;
    logic                  is_label;
    logic                  last_element;
    logic [CLS_W-1:0]      read_row;
    logic [CLS_W-1:0]      read_col;

    modport source (
        output valid, operation, class_index, score, is_label, last_element,
               read_row, read_col,
        input  ready
    );
    modport sink (
        input  valid, operation, class_index, score, is_label, last_element,
               read_row, read_col,
        output ready
    );
endinterface

interface cma_result_if import cma_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [READ_W-1:0]     cell_count;
    logic                  sample_done;
    logic [CLS_W-1:0]      pred_class;
    logic [CLS_W-1:0]      true_class;

    modport source (
        output valid, cell_count, sample_done, pred_class, true_class,
        input  ready
    );
    modport sink (
        input  valid, cell_count, sample_done, pred_class, true_class,
        output ready
    );
endinterface

// File: hdl/cma_ram.sv
module cma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/confusion_matrix_accumulator.sv
// Confusion matrix accumulator. Takes one word per clock while not stalled and returns one
// result word per accepted word, in order. Each word passes an input register (weight
// multiply done on the way in), a decision stage (threshold compare or running weighted
// argmax, cell address, counter RAM read) and a count stage (saturating increment written
// back, read value formed) before the output register; a back-to-back update of the same
// cell is forwarded from the last write. The whole pipeline stalls only while the output
// register holds an untaken result. Clear drops the per-cell valid flags and the RAM is not
// swept, so there is no clearing pass after reset. Write configuration only while idle.
module confusion_matrix_accumulator import cma_pkg::*; #(
    parameter int MAX_CLASSES = DEF_MAX_CLASSES,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    cma_item_if.sink              item,
    cma_result_if.source          result
);

    localparam int CELLS   = MAX_CLASSES * MAX_CLASSES;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int CALC_W  = CELL_AW + CLS_W + 1;
    localparam int CLS_LIM = (MAX_CLASSES < 16) ? MAX_CLASSES : 16;
    localparam int WSEL_W  = $clog2(2 * CFG_DATA_W);
    localparam logic [CC_W-1:0] CC_MIN = CC_W'(2);
    localparam logic [CC_W-1:0] CC_MAX = CC_W'(CLS_LIM);
    localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = {COUNT_WIDTH{1'b1}};

    function automatic logic [CELL_AW-1:0] cell_addr(input logic [CLS_W-1:0] row,
                                                     input logic [CLS_W-1:0] col);
        logic [CALC_W-1:0] a;
        a = CALC_W'(row) * CALC_W'(MAX_CLASSES) + CALC_W'(col);
        return a[CELL_AW-1:0];
    endfunction

    // ---------------- configuration ----------------
    logic                  mode_reg;
    logic [CC_W-1:0]       class_count_reg;
    logic [SCORE_W-1:0]    threshold_reg;
    logic [CFG_DATA_W-1:0] weights_lo_reg;
    logic [CFG_DATA_W-1:0] weights_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            class_count_reg <= RST_CLASS_COUNT;
            threshold_reg   <= RST_THRESHOLD;
            weights_lo_reg  <= RST_WEIGHTS;
            weights_hi_reg  <= RST_WEIGHTS;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MODE:         mode_reg        <= cfg_wr_data[0];
                REG_CLASS_COUNT:  class_count_reg <= cfg_wr_data[CC_W-1:0];
                REG_THRESHOLD:    threshold_reg   <= cfg_wr_data[SCORE_W-1:0];
                REG_WEIGHTS_LOW:  weights_lo_reg  <= cfg_wr_data;
                REG_WEIGHTS_HIGH: weights_hi_reg  <= cfg_wr_data;
                default:          ;
            endcase
        end
    end

    logic [CC_W-1:0] eff_classes;
    always_comb
    begin
        priority if (class_count_reg < CC_MIN)
            eff_classes = CC_MIN;
        else if (class_count_reg > CC_MAX)
            eff_classes = CC_MAX;
        else
            eff_classes = class_count_reg;
    end

    // ---------------- pipeline control ----------------
    logic out_vld_reg;
    logic advance;

    assign advance    = !out_vld_reg || result.ready;
    assign item.ready = advance;

    // ---------------- input register ----------------
    logic [2*CFG_DATA_W-1:0] weights_all;
    logic [WEIGHT_W-1:0]     weight_in;
    logic [WSCORE_W-1:0]     ws_in;

    assign weights_all = {weights_hi_reg, weights_lo_reg};
    assign weight_in   = weights_all[WSEL_W'(item.class_index) * WSEL_W'(WEIGHT_W) +: WEIGHT_W];
    assign ws_in       = {{WEIGHT_W{1'b0}}, item.score} *
                         {{SCORE_W{1'b0}}, weight_in};

    logic                 s1_vld_reg;
    logic [OP_W-1:0]      s1_op_reg;
    logic [CLS_W-1:0]     s1_cls_reg;
    logic [SCORE_W-1:0]   s1_score_reg;
    logic [WSCORE_W-1:0]  s1_ws_reg;
    logic                 s1_lab_reg;
    logic                 s1_last_reg;
    logic [CLS_W-1:0]     s1_rrow_reg;
    logic [CLS_W-1:0]     s1_rcol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (advance)
            s1_vld_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg    <= item.operation;
            s1_cls_reg   <= item.class_index;
            s1_score_reg <= item.score;
            s1_ws_reg    <= ws_in;
            s1_lab_reg   <= item.is_label;
            s1_last_reg  <= item.last_element;
            s1_rrow_reg  <= item.read_row;
            s1_rcol_reg  <= item.read_col;
        end
    end

    // ---------------- decision stage ----------------
    logic [WSCORE_W-1:0] best_ws_reg,    best_ws_next;
    logic [CLS_W-1:0]    best_cls_reg,   best_cls_next;
    logic [CLS_W-1:0]    label_cls_reg,  label_cls_next;
    logic                label_found_reg, label_found_next;
    logic                started_reg,    started_next;

    logic                in_use;
    logic                take_best;
    logic                take_label;
    logic [CLS_W-1:0]    cand_best;
    logic [CLS_W-1:0]    cand_label;
    logic                cand_started;
    logic                cand_found;
    logic                s1_bump;
    logic [CLS_W-1:0]    s1_pred;
    logic [CLS_W-1:0]    s1_act;
    logic                s1_read_ok;
    logic [CELL_AW-1:0]  s1_addr;

    always_comb
    begin
        in_use       = {1'b0, s1_cls_reg} < eff_classes;
        take_best    = in_use && (!started_reg || s1_ws_reg > best_ws_reg);
        take_label   = in_use && s1_lab_reg && !label_found_reg;
        cand_best    = take_best ? s1_cls_reg : best_cls_reg;
        cand_label   = take_label ? s1_cls_reg : label_cls_reg;
        cand_started = started_reg || in_use;
        cand_found   = label_found_reg || take_label;

        best_ws_next     = take_best ? s1_ws_reg : best_ws_reg;
        best_cls_next    = cand_best;
        label_cls_next   = cand_label;
        label_found_next = cand_found;
        started_next     = cand_started;

        s1_bump = 1'b0;
        s1_pred = '0;
        s1_act  = '0;
        if (s1_op_reg == OP_SCORE)
        begin
            if (!mode_reg)
            begin
                s1_bump = 1'b1;
                s1_pred = CLS_W'(s1_score_reg > threshold_reg);
                s1_act  = CLS_W'(s1_lab_reg);
            end
            else if (s1_last_reg)
            begin
                s1_bump = 1'b1;
                s1_pred = cand_started ? cand_best : '0;
                s1_act  = cand_found ? cand_label : '0;
                // Sample closed: reset the running argmax
                best_ws_next     = '0;
                best_cls_next    = '0;
                label_cls_next   = '0;
                label_found_next = 1'b0;
                started_next     = 1'b0;
            end
        end

        s1_read_ok = (32'(s1_rrow_reg) < MAX_CLASSES) && (32'(s1_rcol_reg) < MAX_CLASSES);
        if (s1_op_reg == OP_READ)
            s1_addr = cell_addr(s1_rrow_reg, s1_rcol_reg);
        else
            s1_addr = cell_addr(s1_pred, s1_act);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_ws_reg     <= '0;
            best_cls_reg    <= '0;
            label_cls_reg   <= '0;
            label_found_reg <= 1'b0;
            started_reg     <= 1'b0;
        end
        else if (advance && s1_vld_reg && s1_op_reg == OP_SCORE && mode_reg)
        begin
            best_ws_reg     <= best_ws_next;
            best_cls_reg    <= best_cls_next;
            label_cls_reg   <= label_cls_next;
            label_found_reg <= label_found_next;
            started_reg     <= started_next;
        end
    end

    logic                s2_vld_reg;
    logic [OP_W-1:0]     s2_op_reg;
    logic [CELL_AW-1:0]  s2_addr_reg;
    logic                s2_bump_reg;
    logic [CLS_W-1:0]    s2_pred_reg;
    logic [CLS_W-1:0]    s2_act_reg;
    logic                s2_read_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (advance)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_op_reg      <= s1_op_reg;
            s2_addr_reg    <= s1_addr;
            s2_bump_reg    <= s1_bump;
            s2_pred_reg    <= s1_pred;
            s2_act_reg     <= s1_act;
            s2_read_ok_reg <= s1_read_ok;
        end
    end

    // ---------------- count stage ----------------
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic                   ram_we;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] inc_count;
    logic [READ_W-1:0]      read_val;
    logic                   s2_clear;

    logic [CELLS-1:0]       cell_vld_reg;
    logic                   wr_vld_reg;
    logic [CELL_AW-1:0]     wr_addr_reg;
    logic [COUNT_WIDTH-1:0] wr_data_reg;

    cma_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (CELLS)
    ) u_cells (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (s2_addr_reg),
        .wr_data (inc_count),
        .rd_en   (advance),
        .rd_addr (s1_addr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        // Forward the write made at the edge this word's RAM read was issued
        if (wr_vld_reg && wr_addr_reg == s2_addr_reg)
            cur_count = wr_data_reg;
        else if (cell_vld_reg[s2_addr_reg])
            cur_count = ram_rdata;
        else
            cur_count = '0;
        inc_count = (cur_count == COUNT_FULL) ? cur_count : cur_count + 1'b1;
        ram_we    = advance && s2_vld_reg && s2_bump_reg;
        s2_clear  = advance && s2_vld_reg && s2_op_reg == OP_CLEAR;
    end

    generate
        if (COUNT_WIDTH > READ_W)
        begin : g_sat
            assign read_val = (|cur_count[COUNT_WIDTH-1:READ_W]) ? {READ_W{1'b1}}
                                                                 : cur_count[READ_W-1:0];
        end
        else if (COUNT_WIDTH < READ_W)
        begin : g_ext
            assign read_val = {{(READ_W-COUNT_WIDTH){1'b0}}, cur_count};
        end
        else
        begin : g_same
            assign read_val = cur_count;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_vld_reg <= '0;
            wr_vld_reg   <= 1'b0;
        end
        else
        begin
            if (s2_clear)
                cell_vld_reg <= '0;
            else if (ram_we)
                cell_vld_reg[s2_addr_reg] <= 1'b1;
            if (advance)
                wr_vld_reg <= ram_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            wr_addr_reg <= s2_addr_reg;
            wr_data_reg <= inc_count;
        end
    end

    // ---------------- output register ----------------
    logic [READ_W-1:0] out_count_reg;
    logic              out_done_reg;
    logic [CLS_W-1:0]  out_pred_reg;
    logic [CLS_W-1:0]  out_act_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_count_reg <= (s2_op_reg == OP_READ && s2_read_ok_reg) ? read_val : '0;
            out_done_reg  <= s2_bump_reg;
            out_pred_reg  <= s2_bump_reg ? s2_pred_reg : '0;
            out_act_reg   <= s2_bump_reg ? s2_act_reg : '0;
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.cell_count  = out_count_reg;
    assign result.sample_done = out_done_reg;
    assign result.pred_class  = out_pred_reg;
    assign result.true_class  = out_act_reg;

endmodule

// File: hdl/cma_checker.sv
module cma_checker import cma_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic [READ_W-1:0] cell_count,
    input logic              sample_done,
    input logic [CLS_W-1:0]  pred_class,
    input logic [CLS_W-1:0]  true_class
);

    // Stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid &&
            $stable({cell_count, sample_done, pred_class, true_class}))
        else $error("result word changed while stalled");

    // A counted sample never carries a read value
    a_done_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && sample_done |-> cell_count == '0)
        else $error("cell_count nonzero on a completed sample");

    // Classes are zero unless a sample completed
    a_idle_classes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !sample_done |-> pred_class == '0 && true_class == '0)
        else $error("class fields nonzero without sample_done");

endmodule

bind confusion_matrix_accumulator cma_checker u_cma_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .cell_count  (result.cell_count),
    .sample_done (result.sample_done),
    .pred_class  (result.pred_class),
    .true_class  (result.true_class)
);

// File: dv/tb_confusion_matrix_accumulator.sv
`timescale 1ns / 100ps

module tb_confusion_matrix_accumulator;
    import cma_pkg::*;

    localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;
    localparam int CELL_COUNT = DEF_MAX_CLASSES * DEF_MAX_CLASSES;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [CLS_W-1:0]   class_index;
        logic [SCORE_W-1:0] score;
        logic               is_label;
        logic               last_element;
        logic [CLS_W-1:0]   read_row;
        logic [CLS_W-1:0]   read_col;
    } word_t;

    typedef struct packed {
        logic [READ_W-1:0] cell_count;
        logic              sample_done;
        logic [CLS_W-1:0]  pred_class;
        logic [CLS_W-1:0]  true_class;
    } tally_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    cma_item_if   item_if ();
    cma_result_if res_if ();

    confusion_matrix_accumulator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_if.sink),
        .result      (res_if.source)
    );

    // Register copies
    logic                  mode_r        = 1'b0;
    logic [CC_W-1:0]       class_count_r = RST_CLASS_COUNT;
    logic [SCORE_W-1:0]    threshold_r   = RST_THRESHOLD;
    logic [CFG_DATA_W-1:0] weights_lo_r  = RST_WEIGHTS;
    logic [CFG_DATA_W-1:0] weights_hi_r  = RST_WEIGHTS;

    // Matrix and running argmax state
    logic [DEF_COUNT_WIDTH-1:0] cells [CELL_COUNT] = '{default: '0};
    logic [WSCORE_W-1:0]        top_score   = '0;
    logic [CLS_W-1:0]           top_class   = '0;
    logic [CLS_W-1:0]           truth_class = '0;
    logic                       truth_seen  = 1'b0;
    logic                       in_sample   = 1'b0;

    word_t       word_q [$];
    tally_t      tally_q [$];
    word_t       cur_word;
    logic        word_held = 1'b0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int          faults = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned live_classes();
        if (class_count_r < 2)
            return 2;
        if (class_count_r > DEF_MAX_CLASSES)
            return DEF_MAX_CLASSES;
        return class_count_r;
    endfunction

    function automatic void bump_cell(logic [CLS_W-1:0] row, logic [CLS_W-1:0] col);
        if (cells[{row, col}] != '1)
            cells[{row, col}] += 1'b1;
    endfunction

    function automatic tally_t tally_word(word_t w);
        tally_t                t;
        logic [CFG_DATA_W-1:0] bank;
        logic [WEIGHT_W-1:0]   wt;
        logic [WSCORE_W-1:0]   ws;
        logic [CLS_W-1:0]      pred;
        logic [CLS_W-1:0]      act;
        t = '0;
        case (w.operation)
            OP_READ:
                t.cell_count = READ_W'(cells[{w.read_row, w.read_col}]);
            OP_CLEAR:
                foreach (cells[i])
                    cells[i] = '0;
            OP_SCORE:
                if (!mode_r)
                begin
                    pred = (w.score > threshold_r) ? 4'd1 : 4'd0;
                    bump_cell(pred, {3'b000, w.is_label});
                    t.sample_done = 1'b1;
                    t.pred_class  = pred;
                    t.true_class  = {3'b000, w.is_label};
                end
                else
                begin
                    if (w.class_index < live_classes())
                    begin
                        bank = w.class_index[3] ? weights_hi_r : weights_lo_r;
                        wt   = bank[{w.class_index[2:0], 3'b000} +: WEIGHT_W];
                        ws   = w.score * wt;
                        // first element to reach the maximum keeps it
                        if (!in_sample || ws > top_score)
                        begin
                            top_score = ws;
                            top_class = w.class_index;
                        end
                        in_sample = 1'b1;
                        if (w.is_label && !truth_seen)
                        begin
                            truth_class = w.class_index;
                            truth_seen  = 1'b1;
                        end
                    end
                    if (w.last_element)
                    begin
                        pred = in_sample ? top_class : '0;
                        act  = truth_seen ? truth_class : '0;
                        bump_cell(pred, act);
                        t.sample_done = 1'b1;
                        t.pred_class  = pred;
                        t.true_class  = act;
                        top_score   = '0;
                        top_class   = '0;
                        truth_class = '0;
                        truth_seen  = 1'b0;
                        in_sample   = 1'b0;
                    end
                end
            default: ;
        endcase
        return t;
    endfunction

    function automatic void check_field(string name, logic [READ_W-1:0] want,
                                        logic [READ_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            faults++;
        end
    endfunction

    // Driver: hold a word until taken, then present the next one or idle
    always @(posedge clk)
    begin
        if (!rst_n)
            item_if.valid <= 1'b0;
        else
        begin
            if (item_if.valid && item_if.ready)
            begin
                tally_q.push_back(tally_word(cur_word));
                word_held = 1'b0;
            end
            if (!word_held && word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                cur_word  = word_q.pop_front();
                word_held = 1'b1;
                item_if.valid        <= 1'b1;
                item_if.operation    <= cur_word.operation;
                item_if.class_index  <= cur_word.class_index;
                item_if.score        <= cur_word.score;
                item_if.is_label     <= cur_word.is_label;
                item_if.last_element <= cur_word.last_element;
                item_if.read_row     <= cur_word.read_row;
                item_if.read_col     <= cur_word.read_col;
            end
            else if (!word_held)
                item_if.valid <= 1'b0;
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        tally_t want;
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (tally_q.size() == 0)
                begin
                    $error("result word with nothing pending");
                    faults++;
                end
                else
                begin
                    want = tally_q.pop_front();
                    check_field("cell_count", want.cell_count, res_if.cell_count);
                    check_field("sample_done", want.sample_done, res_if.sample_done);
                    check_field("pred_class", want.pred_class, res_if.pred_class);
                    check_field("true_class", want.true_class, res_if.true_class);
                end
            end
            res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic word_t rnd_word();
        return word_t'($urandom);
    endfunction

    task automatic send_score(input logic [CLS_W-1:0] cls, input logic [SCORE_W-1:0] sc,
                              input logic lab, input logic last);
        word_t w;
        w = rnd_word();
        w.operation    = OP_SCORE;
        w.class_index  = cls;
        w.score        = sc;
        w.is_label     = lab;
        w.last_element = last;
        word_q.push_back(w);
    endtask

    task automatic send_read(input logic [CLS_W-1:0] row, input logic [CLS_W-1:0] col);
        word_t w;
        w = rnd_word();
        w.operation = OP_READ;
        w.read_row  = row;
        w.read_col  = col;
        word_q.push_back(w);
    endtask

    task automatic send_op(input logic [OP_W-1:0] op);
        word_t w;
        w = rnd_word();
        w.operation = op;
        word_q.push_back(w);
    endtask

    task automatic push_noise();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send_score(4'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
        else if (pick < 85)
            send_read($urandom_range(0, 1) ? 4'($urandom) : 4'($urandom_range(0, 2)),
                      $urandom_range(0, 1) ? 4'($urandom) : 4'($urandom_range(0, 2)));
        else if (pick < 91)
            send_op(OP_CLEAR);
        else
            send_op(OP_UNDEF);
    endtask

    // One multi-class sample; mostly well formed, sometimes ragged
    task automatic push_sample();
        int unsigned   n;
        int unsigned   len;
        int unsigned   lab_at;
        int unsigned   k;
        logic          rev;
        logic [SCORE_W-1:0] tie;
        logic [CLS_W-1:0]   cls;
        n      = live_classes();
        len    = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n + 2) : n;
        lab_at = $urandom_range(0, len);
        rev    = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 2))
            0:       tie = '0;
            1:       tie = '1;
            default: tie = 16'($urandom);
        endcase
        for (k = 0; k < len; k++)
        begin
            if (len != n)
                cls = 4'($urandom);
            else
                cls = rev ? 4'(n - 1 - k) : 4'(k);
            if ($urandom_range(0, 24) == 0)
                push_noise();
            send_score(cls, ($urandom_range(0, 2) == 0) ? tie : 16'($urandom),
                       (k == lab_at) || ($urandom_range(0, 11) == 0), k == len - 1);
        end
    endtask

    task automatic fill(input int unsigned n);
        int unsigned target;
        logic [SCORE_W-1:0] near;
        target = word_q.size() + n;
        while (word_q.size() < target)
        begin
            if (mode_r)
            begin
                if ($urandom_range(0, 9) < 8)
                    push_sample();
                else
                    push_noise();
            end
            else if ($urandom_range(0, 99) < 85)
            begin
                near = threshold_r + 16'($urandom_range(0, 2)) - 16'd1;
                send_score(4'($urandom), ($urandom_range(0, 3) == 0) ? near : 16'($urandom),
                           1'($urandom), 1'($urandom));
            end
            else
                push_noise();
        end
    endtask

    task automatic drain();
        while (word_q.size() != 0 || word_held || tally_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        case (idx)
            REG_MODE:         mode_r        = data[0];
            REG_CLASS_COUNT:  class_count_r = data[CC_W-1:0];
            REG_THRESHOLD:    threshold_r   = data[SCORE_W-1:0];
            REG_WEIGHTS_LOW:  weights_lo_r  = data;
            REG_WEIGHTS_HIGH: weights_hi_r  = data;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic mode, input logic [CC_W-1:0] cc,
                             input logic [SCORE_W-1:0] thr,
                             input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi);
        cfg_write(REG_MODE, CFG_DATA_W'(mode));
        cfg_write(REG_CLASS_COUNT, CFG_DATA_W'(cc));
        cfg_write(REG_THRESHOLD, CFG_DATA_W'(thr));
        cfg_write(REG_WEIGHTS_LOW, lo);
        cfg_write(REG_WEIGHTS_HIGH, hi);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Pick a register setting: low extremes, high extremes, or random
    task automatic configure(input logic mode, input int unsigned flavor);
        logic [CC_W-1:0]       cc;
        logic [SCORE_W-1:0]    thr;
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        case (flavor)
            0:
            begin
                cc  = 5'($urandom_range(0, 1));
                thr = '0;
                lo  = '0;
                hi  = {$urandom, $urandom};
            end
            1:
            begin
                cc  = 5'($urandom_range(16, 31));
                thr = '1;
                lo  = '1;
                hi  = '1;
            end
            default:
            begin
                cc  = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(2, 8));
                thr = 16'($urandom);
                lo  = {$urandom, $urandom};
                hi  = {$urandom, $urandom};
            end
        endcase
        write_all(mode, cc, thr, lo, hi);
    endtask

    initial
    begin
        int unsigned regime;
        int unsigned p;
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = '0;
        cfg_wr_data          = '0;
        item_if.valid        = 1'b0;
        item_if.operation    = '0;
        item_if.class_index  = '0;
        item_if.score        = '0;
        item_if.is_label     = 1'b0;
        item_if.last_element = 1'b0;
        item_if.read_row     = '0;
        item_if.read_col     = '0;
        res_if.ready         = 1'b0;
        send_idle_pct        = 6;
        recv_idle_pct        = 78;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // binary decisions at the score extremes and at the default threshold
        send_score(4'($urandom), 16'h0000, 1'b0, 1'($urandom));
        send_score(4'($urandom), 16'h8000, 1'b1, 1'($urandom));
        send_score(4'($urandom), 16'h8001, 1'b0, 1'($urandom));
        send_score(4'($urandom), 16'hFFFF, 1'b1, 1'($urandom));
        send_read(4'd0, 4'd0);
        send_read(4'd0, 4'd1);
        send_read(4'd1, 4'd0);
        send_read(4'd15, 4'd15);
        send_op(OP_UNDEF);
        send_op(OP_CLEAR);
        send_read(4'd1, 4'd1);
        drain();

        // three classes weighted 1, 2 and 4 times the reset weight
        write_all(1'b1, 5'd3, RST_THRESHOLD, 64'h0808_0808_0820_1008, RST_WEIGHTS);
        // three-way tie: first class wins
        send_score(4'd0, 16'h2000, 1'b0, 1'b0);
        send_score(4'd1, 16'h1000, 1'b0, 1'b0);
        send_score(4'd2, 16'h0800, 1'b1, 1'b1);
        // only an unused class: empty sample, label ignored
        send_score(4'd7, 16'hFFFF, 1'b1, 1'b1);
        // no label
        send_score(4'd0, 16'h0001, 1'b0, 1'b0);
        send_score(4'd1, 16'hFFFF, 1'b0, 1'b0);
        send_score(4'd2, 16'h0000, 1'b0, 1'b1);
        // two labels: the first one holds
        send_score(4'd2, 16'hFFFF, 1'b1, 1'b0);
        send_score(4'd0, 16'h4000, 1'b1, 1'b0);
        send_score(4'd1, 16'h0000, 1'b0, 1'b1);
        send_read(4'd0, 4'd2);
        send_read(4'd0, 4'd0);
        send_read(4'd1, 4'd0);
        send_read(4'd2, 4'd2);
        drain();

        for (regime = 0; regime < 3; regime++)
        begin
            case (regime)
                0:       begin send_idle_pct = 6;  recv_idle_pct = 78; end
                1:       begin send_idle_pct = 78; recv_idle_pct = 6;  end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            for (p = 0; p < 4; p++)
            begin
                configure(p[0], (regime < 2 && p < 2) ? regime : 2);
                if (regime == 0 && p == 1)
                begin
                    // hold the sender until everything in flight has come back
                    fill(42);
                    drain();
                    fill(43);
                end
                else
                    fill(85);
                drain();
            end
        end

        repeat (10) @(posedge clk);
        if (faults == 0 && tally_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
hdl/cma_pkg.sv
hdl/cma_ifs.sv
hdl/cma_ram.sv
hdl/confusion_matrix_accumulator.sv
hdl/cma_checker.sv
dv/tb_confusion_matrix_accumulator.sv
